[sv/cell_voltage_and_current_converter_top_assert.svh]
// Assertion macros shared by the converter's checker.
// Depends on nothing; the including scope provides aclk and aresetn.
`ifndef CELL_VOLTAGE_AND_CURRENT_CONVERTER_TOP_ASSERT_SVH
`define CELL_VOLTAGE_AND_CURRENT_CONVERTER_TOP_ASSERT_SVH

// Property checked at every clock edge once reset is released
`define CVCC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("cvcc check failed");

// Property checked at every clock edge, reset included
`define CVCC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("cvcc check failed");

`endif

[sv/cvcc_pkg.sv]
// Types and constants of the cell voltage and current converter.
// Used by cvcc_serial_engine and the top level; depends on nothing.
package cvcc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAIN_ONE = 2'd0,
        CFG_GAIN_TWO = 2'd1,
        CFG_OFFSET   = 2'd2,
        CFG_SHUNT    = 2'd3
    } cfg_idx_t;

    // Sample kinds
    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_CURRENT = 1'b1;

    // Conversion constants
    localparam logic [8:0]         GAIN_BASE_UV  = 9'd365;
    localparam logic [9:0]         CURRENT_SCALE = 10'd844;
    localparam logic signed [17:0] UV_PER_MV     = 18'sd1000;
    localparam logic [14:0]        MV_DIVISOR    = 15'd1000;
    localparam logic [14:0]        DENOM_SCALE   = 15'd100;
    localparam logic [13:0]        HALF_SCALE    = 14'd50;
    localparam logic [7:0]         SHUNT_RESET   = 8'd1;
    localparam logic [16:0]        PACK_SUM_MAX  = 17'h1FFFF;

    // Serial engine sizing: radix-4 multiply steps, restoring divide steps
    localparam int MUL_STEPS = 8;
    localparam int DIV_STEPS = 19;
    localparam int CNT_W     = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BIAS,
        ST_DIV,
        ST_DONE
    } eng_state_t;

    // Top level to engine
    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctrl_t;

    // Engine to top level
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

[sv/cvcc_serial_engine.sv]
// Serial multiply, offset and divide unit: (mcand * mplier + bias) / divisor.
// Radix-4 shift-add multiplier then restoring divider, one quotient bit a cycle. Uses cvcc_pkg.
module cvcc_serial_engine
    import cvcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  eng_ctrl_t          ctrl,
    input  logic [9:0]         mcand,
    input  logic [15:0]        mplier,
    input  logic signed [17:0] bias,
    input  logic [14:0]        divisor,
    output eng_stat_t          stat,
    output logic [18:0]        quotient
);

    eng_state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [24:0]        mcand_reg;
    logic [15:0]        mplier_reg;
    logic [24:0]        acc_reg;
    logic signed [17:0] bias_reg;
    logic [14:0]        div_reg;
    logic [14:0]        rem_reg;
    logic [18:0]        quo_reg;

    logic               mul_last;
    logic               div_last;
    logic [24:0]        partial;
    logic signed [26:0] biased;
    logic [24:0]        num;
    logic [15:0]        trial;
    logic               ge;
    logic [15:0]        diff;

    assign mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // One radix-4 digit of the multiplier a cycle
    assign partial = 25'(mcand_reg * {23'd0, mplier_reg[1:0]});

    // Add the offset term, clamp negative sums to zero
    assign biased = $signed({2'b00, acc_reg}) + 27'(bias_reg);
    assign num    = biased[26] ? '0 : biased[24:0];

    // Restoring divide step
    assign trial = {rem_reg, quo_reg[18]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctrl.start) state_next = ST_MUL;
            ST_MUL:  if (mul_last)   state_next = ST_BIAS;
            ST_BIAS: state_next = ST_DIV;
            ST_DIV:  if (div_last)   state_next = ST_DONE;
            ST_DONE: if (ctrl.ack)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Status outputs
    always_comb begin
        stat.idle = (state_reg == ST_IDLE);
        stat.done = (state_reg == ST_DONE);
    end

    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MUL && !mul_last) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (state_reg == ST_DIV && !div_last) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                mcand_reg  <= {15'd0, mcand};
                mplier_reg <= mplier;
                acc_reg    <= '0;
                bias_reg   <= bias;
                div_reg    <= divisor;
            end
            ST_MUL: begin
                acc_reg    <= acc_reg + partial;
                mcand_reg  <= {mcand_reg[22:0], 2'b00};
                mplier_reg <= {2'b00, mplier_reg[15:2]};
            end
            ST_BIAS: begin
                // quotient fits 19 bits, so the top bits are below the divisor
                rem_reg <= {9'd0, num[24:19]};
                quo_reg <= num[18:0];
            end
            ST_DIV: begin
                rem_reg <= ge ? diff[14:0] : trial[14:0];
                quo_reg <= {quo_reg[17:0], ge};
            end
            ST_DONE: begin
                quo_reg <= quo_reg;
            end
            default: begin
                acc_reg <= '0;
            end
        endcase
    end

endmodule

[sv/cell_voltage_and_current_converter_top.sv]
// A request runs through the 8-step radix-4 multiplier, the bias state and the 19-step
// restoring divider in cvcc_serial_engine; its result is then registered for output.
// No new request is taken until the engine has handed that result on and is idle.
// A finished result waits in the output register while the next request runs.
// Reset (aresetn, synchronous, active low): gain and offset bytes 0, shunt 1,
// pack sum 0, no result pending. Uses cvcc_pkg and cvcc_serial_engine.
module cell_voltage_and_current_converter_top
    import cvcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // sample requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [15:0]        s_sample_word,
    input  logic               s_last_cell,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_result_kind,
    output logic [12:0]        m_cell_millivolts,
    output logic [16:0]        m_pack_millivolts,
    output logic               m_pack_valid,
    output logic signed [19:0] m_current_milliamps,
    output logic               m_error_flag
);

    logic [7:0] cfg_gain_one_reg;
    logic [7:0] cfg_gain_two_reg;
    logic [7:0] cfg_offset_reg;
    logic [7:0] cfg_shunt_reg;

    logic        kind_reg;
    logic        last_reg;
    logic        err_reg;
    logic        neg_reg;
    logic [16:0] pack_sum_reg;

    logic               m_valid_reg;
    logic               res_kind_reg;
    logic [12:0]        res_cell_reg;
    logic [16:0]        res_pack_reg;
    logic               res_pack_valid_reg;
    logic signed [19:0] res_current_reg;
    logic               res_error_reg;

    eng_ctrl_t          eng_ctrl;
    eng_stat_t          eng_stat;
    logic [18:0]        eng_quo;
    logic               accept;
    logic [8:0]         gain;
    logic [15:0]        magnitude;
    logic signed [17:0] offset_uv;
    logic [13:0]        half_denom;
    logic [14:0]        denom;
    logic [9:0]         op_mcand;
    logic [15:0]        op_mplier;
    logic signed [17:0] op_bias;
    logic [14:0]        op_divisor;
    logic [17:0]        sum_wide;
    logic [16:0]        sum_sat;
    logic [19:0]        q_wide;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_gain_one_reg <= '0;
            cfg_gain_two_reg <= '0;
            cfg_offset_reg   <= '0;
            cfg_shunt_reg    <= SHUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_ONE: cfg_gain_one_reg <= cfg_data;
                CFG_GAIN_TWO: cfg_gain_two_reg <= cfg_data;
                CFG_OFFSET:   cfg_offset_reg   <= cfg_data;
                CFG_SHUNT:    cfg_shunt_reg    <= cfg_data;
                default:      cfg_shunt_reg    <= cfg_shunt_reg;
            endcase
        end
    end

    // Operands for the serial engine
    assign s_ready = eng_stat.idle;
    assign accept  = s_valid && s_ready;

    assign gain       = GAIN_BASE_UV + {4'd0, cfg_gain_one_reg[3:2], cfg_gain_two_reg[7:5]};
    assign magnitude  = s_sample_word[15] ? (16'd0 - s_sample_word) : s_sample_word;
    assign offset_uv  = 18'($signed(cfg_offset_reg) * UV_PER_MV);
    assign half_denom = 14'(cfg_shunt_reg) * HALF_SCALE;
    assign denom      = 15'(cfg_shunt_reg) * DENOM_SCALE;

    always_comb begin
        if (s_cmd == KIND_CURRENT) begin
            op_mcand   = CURRENT_SCALE;
            op_mplier  = magnitude;
            op_bias    = $signed({4'd0, half_denom});
            op_divisor = denom;
        end else begin
            op_mcand   = {1'b0, gain};
            op_mplier  = {2'b00, s_sample_word[13:0]};
            op_bias    = offset_uv;
            op_divisor = MV_DIVISOR;
        end
    end

    assign eng_ctrl.start = accept;
    assign eng_ctrl.ack   = eng_stat.done && (!m_valid_reg || m_ready);

    cvcc_serial_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (eng_ctrl),
        .mcand    (op_mcand),
        .mplier   (op_mplier),
        .bias     (op_bias),
        .divisor  (op_divisor),
        .stat     (eng_stat),
        .quotient (eng_quo)
    );

    // Request attributes kept while the engine runs
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_cmd;
            last_reg <= s_last_cell;
            err_reg  <= (s_cmd == KIND_CURRENT) && (cfg_shunt_reg == 8'd0);
            neg_reg  <= s_sample_word[15];
        end
    end

    // Saturating pack sum and signed current
    assign sum_wide = {1'b0, pack_sum_reg} + {5'd0, eng_quo[12:0]};
    assign sum_sat  = sum_wide[17] ? PACK_SUM_MAX : sum_wide[16:0];
    assign q_wide   = {1'b0, eng_quo};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_sum_reg <= '0;
        end else if (eng_ctrl.ack && kind_reg == KIND_CELL) begin
            pack_sum_reg <= last_reg ? 17'd0 : sum_sat;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_ctrl.ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_ctrl.ack) begin
            res_kind_reg <= kind_reg;
            if (kind_reg == KIND_CELL) begin
                res_cell_reg       <= eng_quo[12:0];
                res_pack_reg       <= last_reg ? sum_sat : 17'd0;
                res_pack_valid_reg <= last_reg;
                res_current_reg    <= '0;
                res_error_reg      <= 1'b0;
            end else begin
                res_cell_reg       <= '0;
                res_pack_reg       <= '0;
                res_pack_valid_reg <= 1'b0;
                res_error_reg      <= err_reg;
                if (err_reg) begin
                    res_current_reg <= '0;
                end else if (neg_reg) begin
                    res_current_reg <= $signed(20'd0 - q_wide);
                end else begin
                    res_current_reg <= $signed(q_wide);
                end
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_kind       = res_kind_reg;
    assign m_cell_millivolts   = res_cell_reg;
    assign m_pack_millivolts   = res_pack_reg;
    assign m_pack_valid        = res_pack_valid_reg;
    assign m_current_milliamps = res_current_reg;
    assign m_error_flag        = res_error_reg;

endmodule

[sv/cvcc_checker.sv]
// Port-level checks on the converter, bound to the top level.
// Depends on cell_voltage_and_current_converter_top_assert.svh.
`include "cell_voltage_and_current_converter_top_assert.svh"

module cvcc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_result_kind,
    input logic [12:0]        m_cell_millivolts,
    input logic               m_pack_valid,
    input logic signed [19:0] m_current_milliamps,
    input logic               m_error_flag
);

    // a pending result is not withdrawn
    `CVCC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid)

    // one request at a time: ready drops after an accepted request
    `CVCC_ASSERT(a_one_in_flight, s_valid && s_ready |=> !s_ready)

    // pack sums only come with cell results
    `CVCC_ASSERT(a_pack_on_cell, m_valid && m_pack_valid |-> !m_result_kind)

    // current results carry no cell voltage
    `CVCC_ASSERT(a_current_clean, m_valid && m_result_kind |-> m_cell_millivolts == 13'd0)

    // an error result reads zero current
    `CVCC_ASSERT(a_error_zero,
        m_valid && m_error_flag |-> m_result_kind && m_current_milliamps == 20'sd0)

endmodule

bind cell_voltage_and_current_converter_top cvcc_checker u_cvcc_checker (.*);
